[hw/rtl/gamepad_mecanum_drive_mixer_top_macros.svh]
// ----------------------------------------------------------------------------
// Drive mixer assertion macros
// Concurrent assertion helpers shared by the drive mixer RTL.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_MECANUM_DRIVE_MIXER_TOP_MACROS_SVH
`define GAMEPAD_MECANUM_DRIVE_MIXER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define GMDM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define GMDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GMDM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GMDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/gmdm_pkg.sv]
// ----------------------------------------------------------------------------
// Drive mixer package
// Shared types, widths and button/command codes for the mecanum drive mixer.
// ----------------------------------------------------------------------------
package gmdm_pkg;

   // Field widths.
   localparam int AXIS_W     = 8;
   localparam int DZ_W       = 7;
   localparam int SPEED_W    = 13;
   localparam int PROD_W     = AXIS_W + SPEED_W;
   localparam int QUOT_W     = 15;
   localparam int WHEEL_W    = 14;
   localparam int TIMER_W    = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Drive command codes.
   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_SET  = 2'd1,
      CMD_STOP = 2'd2
   } drive_cmd_type;

   // Action codes.
   localparam logic [2:0] ACT_NONE          = 3'd0;
   localparam logic [2:0] ACT_LOAD_TRIANGLE = 3'd1;
   localparam logic [2:0] ACT_LOAD_SQUARE   = 3'd2;
   localparam logic [2:0] ACT_LOAD_X        = 3'd3;
   localparam logic [2:0] ACT_LOAD_CIRCLE   = 3'd4;
   localparam logic [2:0] ACT_UNLD_TRIANGLE = 3'd5;
   localparam logic [2:0] ACT_UNLD_SQUARE   = 3'd6;
   localparam logic [2:0] ACT_UNLD_X        = 3'd7;

   // Tray angle codes.
   localparam logic [2:0] TRAY_NONE = 3'd0;
   localparam logic [2:0] TRAY_0    = 3'd1;
   localparam logic [2:0] TRAY_90   = 3'd2;
   localparam logic [2:0] TRAY_180  = 3'd3;
   localparam logic [2:0] TRAY_270  = 3'd4;

   // Register indexes.
   localparam logic [2:0] REG_STICK_CENTER  = 3'd0;
   localparam logic [2:0] REG_DEAD_ZONE     = 3'd1;
   localparam logic [2:0] REG_MAX_WHEEL     = 3'd2;
   localparam logic [2:0] REG_MAX_ROTATE    = 3'd3;
   localparam logic [2:0] REG_POLL_PERIOD   = 3'd4;
   localparam logic [2:0] REG_IDLE_STOP     = 3'd5;

   // First button byte.
   localparam logic [7:0] BTN_START = 8'h08;
   localparam logic [7:0] BTN_UP    = 8'h10;
   localparam logic [7:0] BTN_RIGHT = 8'h20;
   localparam logic [7:0] BTN_DOWN  = 8'h40;
   localparam logic [7:0] BTN_LEFT  = 8'h80;

   // Second button byte.
   localparam logic [7:0] BTN_L2       = 8'h01;
   localparam logic [7:0] BTN_R2       = 8'h02;
   localparam logic [7:0] BTN_L1       = 8'h04;
   localparam logic [7:0] BTN_R1       = 8'h08;
   localparam logic [7:0] BTN_TRIANGLE = 8'h10;
   localparam logic [7:0] BTN_CIRCLE   = 8'h20;
   localparam logic [7:0] BTN_X        = 8'h40;
   localparam logic [7:0] BTN_SQUARE   = 8'h80;

   // Scaled axis before the divide by 127: sign and magnitude.
   typedef struct packed {
      logic              neg;
      logic [PROD_W-1:0] mag;
   } axis_prod_type;

endpackage

[hw/rtl/gmdm_axis.sv]
// ----------------------------------------------------------------------------
// Drive mixer axis front end
// Centers one raw stick axis, applies the dead zone and multiplies the
// magnitude by the axis scale.
// ----------------------------------------------------------------------------
module gmdm_axis
   import gmdm_pkg::*;
(
   input  logic [AXIS_W-1:0]  raw,
   input  logic               reverse,
   input  logic [AXIS_W-1:0]  center,
   input  logic [DZ_W-1:0]    dead_zone,
   input  logic [SPEED_W-1:0] scale,
   output axis_prod_type      prod
);

   logic signed [AXIS_W:0] offset;
   logic [AXIS_W-1:0]      offset_mag;
   logic                   in_dead_zone;

   // Signed offset from the rest position, reversed for the forward axis.
   always_comb begin
      if (reverse) begin
         offset = $signed({1'b0, center}) - $signed({1'b0, raw});
      end else begin
         offset = $signed({1'b0, raw}) - $signed({1'b0, center});
      end
   end

   // The magnitude of a 9-bit offset never exceeds 255.
   assign offset_mag   = offset[AXIS_W] ? AXIS_W'(-offset) : offset[AXIS_W-1:0];
   assign in_dead_zone = offset_mag < {1'b0, dead_zone};

   // Scaled magnitude; the sign travels alongside.
   assign prod.neg = offset[AXIS_W];
   assign prod.mag = in_dead_zone ? '0 : PROD_W'(offset_mag) * PROD_W'(scale);

endmodule

[hw/rtl/gamepad_mecanum_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// Gamepad mecanum drive mixer
// Turns gamepad polls into wheel speed, stop, action and tray commands.
// ----------------------------------------------------------------------------
// Pipeline: a taken request is registered in the axis multiply register,
//   then in the result register by the divide, mix and clamp stage that
//   updates the drive state; rsp_valid rises as it reaches that register.
// Throughput: one transaction per cycle unless a held result stalls the pipe.
// Reset: synchronous, active high; configuration registers return to their
//   defaults and all drive state (enable, idle timer, button history) clears.
// ----------------------------------------------------------------------------
`include "gamepad_mecanum_drive_mixer_top_macros.svh"

module gamepad_mecanum_drive_mixer_top
   import gmdm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Poll channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode_valid,
   input  logic [7:0]              req_dpad_buttons,
   input  logic [7:0]              req_shape_buttons,
   input  logic [AXIS_W-1:0]       req_left_vertical,
   input  logic [AXIS_W-1:0]       req_left_horizontal,
   input  logic [AXIS_W-1:0]       req_right_horizontal,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_drive_cmd,
   output logic                    rsp_halt_actions,
   output logic                    rsp_unlock_event,
   output logic signed [WHEEL_W-1:0] rsp_wheel_front_left,
   output logic signed [WHEEL_W-1:0] rsp_wheel_front_right,
   output logic signed [WHEEL_W-1:0] rsp_wheel_rear_left,
   output logic signed [WHEEL_W-1:0] rsp_wheel_rear_right,
   output logic [2:0]              rsp_action_start,
   output logic [2:0]              rsp_tray_angle,
   // Register port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // Divide a nonnegative scaled axis by 127, truncating. The estimate uses
   // three terms of 1/127 = 2^-7 + 2^-14 + 2^-21 + ... and is at most one low.
   function automatic logic [QUOT_W-1:0] div127(input logic [PROD_W-1:0] x);
      logic [PROD_W+15:0] sum;
      logic [QUOT_W-1:0]  q0;
      logic [PROD_W:0]    rem;
      sum = ({16'd0, x} << 14) + ({16'd0, x} << 7) + {16'd0, x};
      q0  = sum[PROD_W+QUOT_W-1:PROD_W];
      rem = {1'b0, x} - (((PROD_W+1)'(q0) << 7) - (PROD_W+1)'(q0));
      if (rem >= (PROD_W+1)'(127)) begin
         q0 = q0 + QUOT_W'(1);
      end
      return q0;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [AXIS_W-1:0]  stick_center_ff;
   logic [DZ_W-1:0]    dead_zone_ff;
   logic [SPEED_W-1:0] max_wheel_ff;
   logic [SPEED_W-1:0] max_rotate_ff;
   logic [7:0]         poll_period_ff;
   logic [TIMER_W-1:0] idle_stop_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_center_ff <= AXIS_W'(128);
         dead_zone_ff    <= DZ_W'(10);
         max_wheel_ff    <= SPEED_W'(1000);
         max_rotate_ff   <= SPEED_W'(500);
         poll_period_ff  <= 8'd20;
         idle_stop_ff    <= TIMER_W'(500);
      end else if (csr_write) begin
         case (csr_index)
            REG_STICK_CENTER: stick_center_ff <= csr_pwdata[AXIS_W-1:0];
            REG_DEAD_ZONE:    dead_zone_ff    <= csr_pwdata[DZ_W-1:0];
            REG_MAX_WHEEL:    max_wheel_ff    <= csr_pwdata[SPEED_W-1:0];
            REG_MAX_ROTATE:   max_rotate_ff   <= csr_pwdata[SPEED_W-1:0];
            REG_POLL_PERIOD:  poll_period_ff  <= csr_pwdata[7:0];
            REG_IDLE_STOP:    idle_stop_ff    <= csr_pwdata[TIMER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (csr_index)
         REG_STICK_CENTER: csr_prdata = CSR_DATA_W'(stick_center_ff);
         REG_DEAD_ZONE:    csr_prdata = CSR_DATA_W'(dead_zone_ff);
         REG_MAX_WHEEL:    csr_prdata = CSR_DATA_W'(max_wheel_ff);
         REG_MAX_ROTATE:   csr_prdata = CSR_DATA_W'(max_rotate_ff);
         REG_POLL_PERIOD:  csr_prdata = CSR_DATA_W'(poll_period_ff);
         REG_IDLE_STOP:    csr_prdata = CSR_DATA_W'(idle_stop_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline handshake
   // ------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_fire;
   logic item_fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign item_fire = s1_valid_ff && advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: centered, dead-zoned and scaled axes
   // ------------------------------------------------------------------
   axis_prod_type fwd_prod;
   axis_prod_type str_prod;
   axis_prod_type rot_prod;
   axis_prod_type s1_fwd_ff;
   axis_prod_type s1_str_ff;
   axis_prod_type s1_rot_ff;
   logic          s1_mode_ff;
   logic [7:0]    s1_dpad_ff;
   logic [7:0]    s1_shape_ff;

   gmdm_axis u_axis_fwd (
      .raw       (req_left_vertical),
      .reverse   (1'b1),
      .center    (stick_center_ff),
      .dead_zone (dead_zone_ff),
      .scale     (max_wheel_ff),
      .prod      (fwd_prod)
   );

   gmdm_axis u_axis_str (
      .raw       (req_left_horizontal),
      .reverse   (1'b0),
      .center    (stick_center_ff),
      .dead_zone (dead_zone_ff),
      .scale     (max_wheel_ff),
      .prod      (str_prod)
   );

   gmdm_axis u_axis_rot (
      .raw       (req_right_horizontal),
      .reverse   (1'b0),
      .center    (stick_center_ff),
      .dead_zone (dead_zone_ff),
      .scale     (max_rotate_ff),
      .prod      (rot_prod)
   );

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_fwd_ff   <= fwd_prod;
         s1_str_ff   <= str_prod;
         s1_rot_ff   <= rot_prod;
         s1_mode_ff  <= req_mode_valid;
         s1_dpad_ff  <= req_dpad_buttons;
         s1_shape_ff <= req_shape_buttons;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: divide, mix, clamp and drive state
   // ------------------------------------------------------------------
   logic [QUOT_W-1:0]          fwd_q;
   logic [QUOT_W-1:0]          str_q;
   logic [QUOT_W-1:0]          rot_q;
   logic signed [QUOT_W+1:0]   fwd_s;
   logic signed [QUOT_W+1:0]   str_s;
   logic signed [QUOT_W+1:0]   rot_s;
   logic signed [QUOT_W+1:0]   lim_pos;
   logic signed [QUOT_W+1:0]   lim_neg;
   logic signed [QUOT_W+1:0]   mix [4];
   logic signed [WHEEL_W-1:0]  wheel [4];
   logic                       axes_zero;

   assign fwd_q = div127(s1_fwd_ff.mag);
   assign str_q = div127(s1_str_ff.mag);
   assign rot_q = div127(s1_rot_ff.mag);

   // Restore the sign after the truncating divide.
   assign fwd_s = s1_fwd_ff.neg ? -$signed({2'b00, fwd_q}) : $signed({2'b00, fwd_q});
   assign str_s = s1_str_ff.neg ? -$signed({2'b00, str_q}) : $signed({2'b00, str_q});
   assign rot_s = s1_rot_ff.neg ? -$signed({2'b00, rot_q}) : $signed({2'b00, rot_q});

   assign axes_zero = (fwd_q == '0) && (str_q == '0) && (rot_q == '0);

   // Full-width mecanum mix followed by a symmetric clamp.
   assign lim_pos = $signed({4'd0, max_wheel_ff});
   assign lim_neg = -lim_pos;
   assign mix[0]  = fwd_s + str_s + rot_s;
   assign mix[1]  = fwd_s - str_s - rot_s;
   assign mix[2]  = fwd_s - str_s + rot_s;
   assign mix[3]  = fwd_s + str_s - rot_s;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (mix[i] > lim_pos) begin
            wheel[i] = lim_pos[WHEEL_W-1:0];
         end else if (mix[i] < lim_neg) begin
            wheel[i] = lim_neg[WHEEL_W-1:0];
         end else begin
            wheel[i] = mix[i][WHEEL_W-1:0];
         end
      end
   end

   // Drive state registers.
   logic               drive_enabled_ff, drive_enabled_in;
   logic               idle_armed_ff, idle_armed_in;
   logic               idle_locked_ff, idle_locked_in;
   logic [TIMER_W-1:0] idle_timer_ff, idle_timer_in;
   logic [7:0]         last_dpad_ff, last_dpad_in;
   logic [7:0]         last_shape_ff, last_shape_in;

   // Result fields for the transaction in stage 2.
   drive_cmd_type      cmd;
   logic               halt;
   logic               unlock;
   logic               wheels_on;
   logic [2:0]         act;
   logic [2:0]         tray;
   logic [7:0]         shape_rose;
   logic [7:0]         dpad_rose;
   logic [TIMER_W:0]   timer_sum;
   logic [TIMER_W-1:0] timer_sat;
   logic               stop_now;
   logic               l1_only;
   logic               l2_only;

   assign stop_now   = !s1_mode_ff || ((s1_shape_ff & (BTN_R1 | BTN_R2)) == (BTN_R1 | BTN_R2));
   assign shape_rose = s1_shape_ff & ~last_shape_ff;
   assign dpad_rose  = s1_dpad_ff & ~last_dpad_ff;
   assign l1_only    = ((s1_shape_ff & BTN_L1) != '0) && ((s1_shape_ff & BTN_L2) == '0);
   assign l2_only    = ((s1_shape_ff & BTN_L2) != '0) && ((s1_shape_ff & BTN_L1) == '0);
   assign timer_sum  = {1'b0, idle_timer_ff} + (TIMER_W+1)'(poll_period_ff);
   assign timer_sat  = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];

   always_comb begin
      drive_enabled_in = drive_enabled_ff;
      idle_armed_in    = idle_armed_ff;
      idle_locked_in   = idle_locked_ff;
      idle_timer_in    = idle_timer_ff;
      last_dpad_in     = last_dpad_ff;
      last_shape_in    = last_shape_ff;
      cmd              = CMD_NONE;
      halt             = 1'b0;
      unlock           = 1'b0;
      wheels_on        = 1'b0;
      act              = ACT_NONE;
      tray             = TRAY_NONE;

      if (stop_now) begin
         // Lost analog mode or emergency shoulder combination.
         cmd              = CMD_STOP;
         halt             = 1'b1;
         drive_enabled_in = 1'b0;
         idle_armed_in    = 1'b0;
      end else if (!drive_enabled_ff) begin
         // Locked out: hold the wheels until START.
         cmd = CMD_STOP;
         if ((s1_dpad_ff & BTN_START) != '0) begin
            unlock           = 1'b1;
            drive_enabled_in = 1'b1;
         end
         idle_armed_in = 1'b0;
      end else begin
         // Driving: idle handling or wheel speeds.
         if (axes_zero) begin
            if (idle_locked_ff) begin
               cmd = CMD_NONE;
            end else if (!idle_armed_ff) begin
               idle_armed_in = 1'b1;
               idle_timer_in = '0;
               cmd           = CMD_SET;
            end else begin
               idle_timer_in = timer_sat;
               if (timer_sat >= idle_stop_ff) begin
                  cmd            = CMD_STOP;
                  idle_armed_in  = 1'b0;
                  idle_locked_in = 1'b1;
               end
            end
         end else begin
            idle_armed_in  = 1'b0;
            idle_timer_in  = '0;
            idle_locked_in = 1'b0;
            cmd            = CMD_SET;
            wheels_on      = 1'b1;
         end

         // Action selection on button press edges, first match wins.
         if (l1_only) begin
            if ((shape_rose & BTN_TRIANGLE) != '0) begin
               act = ACT_LOAD_TRIANGLE;
            end else if ((shape_rose & BTN_SQUARE) != '0) begin
               act = ACT_LOAD_SQUARE;
            end else if ((shape_rose & BTN_X) != '0) begin
               act = ACT_LOAD_X;
            end else if ((shape_rose & BTN_CIRCLE) != '0) begin
               act = ACT_LOAD_CIRCLE;
            end
         end else if (l2_only) begin
            if ((shape_rose & BTN_TRIANGLE) != '0) begin
               act = ACT_UNLD_TRIANGLE;
            end else if ((shape_rose & BTN_SQUARE) != '0) begin
               act = ACT_UNLD_SQUARE;
            end else if ((shape_rose & BTN_X) != '0) begin
               act = ACT_UNLD_X;
            end
         end

         // Tray angle on d-pad press edges.
         if ((dpad_rose & BTN_DOWN) != '0) begin
            tray = TRAY_0;
         end else if ((dpad_rose & BTN_LEFT) != '0) begin
            tray = TRAY_90;
         end else if ((dpad_rose & BTN_UP) != '0) begin
            tray = TRAY_180;
         end else if ((dpad_rose & BTN_RIGHT) != '0) begin
            tray = TRAY_270;
         end

         last_dpad_in  = s1_dpad_ff;
         last_shape_in = s1_shape_ff;
      end
   end

   // State advances only when a transaction moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_enabled_ff <= 1'b0;
         idle_armed_ff    <= 1'b0;
         idle_locked_ff   <= 1'b0;
         idle_timer_ff    <= '0;
         last_dpad_ff     <= '0;
         last_shape_ff    <= '0;
      end else if (item_fire) begin
         drive_enabled_ff <= drive_enabled_in;
         idle_armed_ff    <= idle_armed_in;
         idle_locked_ff   <= idle_locked_in;
         idle_timer_ff    <= idle_timer_in;
         last_dpad_ff     <= last_dpad_in;
         last_shape_ff    <= last_shape_in;
      end
   end

   // Result register.
   logic [1:0]                rsp_drive_cmd_ff;
   logic                      rsp_halt_ff;
   logic                      rsp_unlock_ff;
   logic signed [WHEEL_W-1:0] rsp_wheel_ff [4];
   logic [2:0]                rsp_action_ff;
   logic [2:0]                rsp_tray_ff;

   always_ff @(posedge clock) begin
      if (item_fire) begin
         rsp_drive_cmd_ff <= cmd;
         rsp_halt_ff      <= halt;
         rsp_unlock_ff    <= unlock;
         rsp_action_ff    <= act;
         rsp_tray_ff      <= tray;
         for (int i = 0; i < 4; i++) begin
            rsp_wheel_ff[i] <= wheels_on ? wheel[i] : '0;
         end
      end
   end

   assign rsp_drive_cmd         = rsp_drive_cmd_ff;
   assign rsp_halt_actions      = rsp_halt_ff;
   assign rsp_unlock_event      = rsp_unlock_ff;
   assign rsp_wheel_front_left  = rsp_wheel_ff[0];
   assign rsp_wheel_front_right = rsp_wheel_ff[1];
   assign rsp_wheel_rear_left   = rsp_wheel_ff[2];
   assign rsp_wheel_rear_right  = rsp_wheel_ff[3];
   assign rsp_action_start      = rsp_action_ff;
   assign rsp_tray_angle        = rsp_tray_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Wheels carry speed only with a set-speed command.
   `GMDM_ASSERT_IMPLY(a_wheels_need_set, clock, reset,
      rsp_valid_ff && (rsp_drive_cmd_ff != CMD_SET),
      (rsp_wheel_ff[0] == '0) && (rsp_wheel_ff[1] == '0) &&
      (rsp_wheel_ff[2] == '0) && (rsp_wheel_ff[3] == '0),
      "wheel speed without set command")

   // A pending unlock result means driving is now enabled.
   `GMDM_ASSERT_IMPLY(a_unlock_enables, clock, reset,
      rsp_valid_ff && rsp_unlock_ff,
      drive_enabled_ff && (rsp_drive_cmd_ff == CMD_STOP),
      "unlock result without enabled drive")

   // The idle machine is never armed and latched at once.
   `GMDM_ASSERT_IMPLY(a_idle_exclusive, clock, reset,
      idle_armed_ff, !idle_locked_ff,
      "idle armed while latched")

   // A halt always comes with a full stop and drops the enable.
   `GMDM_ASSERT_NEXT(a_halt_disables, clock, reset,
      item_fire && stop_now,
      !drive_enabled_ff && rsp_halt_ff && (rsp_drive_cmd_ff == CMD_STOP),
      "halt did not disable driving")

endmodule
